// ----- rtl/core/bgtpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bgtpc_pkg
// shared types and constants of the background task priority classifier
// ----------------------------------------------------------------------------
package bgtpc_pkg;

	typedef enum logic [1:0] {
		CAT_OTHER = 2'd0,
		CAT_FLUSH = 2'd1,
		CAT_L0    = 2'd2,
		CAT_COMP  = 2'd3
	} cat_t;

	typedef enum logic [1:0] {
		Q_SHARED = 2'd0,
		Q_COMP   = 2'd1,
		Q_PRIO   = 2'd2,
		Q_UNUSED = 2'd3
	} queue_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_THREAD = 2'd1,
		ST_MISS   = 2'd2,
		ST_STALE  = 2'd3
	} status_t;

	localparam logic [1:0] KIND_FLUSH = 2'd1;
	localparam logic [1:0] KIND_COMP  = 2'd2;

	localparam logic [2:0] REG_FIFO      = 3'd0;
	localparam logic [2:0] REG_MAX_AGE   = 3'd1;
	localparam logic [2:0] REG_IMM_THR   = 3'd2;
	localparam logic [2:0] REG_BYTES_THR = 3'd3;
	localparam logic [2:0] REG_L0_THR    = 3'd4;
	localparam logic [2:0] REG_FL_SLICE  = 3'd5;
	localparam logic [2:0] REG_L0_SLICE  = 3'd6;
	localparam logic [2:0] REG_CP_SLICE  = 3'd7;

	localparam logic [39:0] SHARED_QUANTUM_DEF = 40'd20000000;
	localparam logic [63:0] DEF_MAX_AGE     = 64'd3000000000;
	localparam logic [15:0] DEF_IMM_THR     = 16'd1;
	localparam logic [47:0] DEF_BYTES_THR   = 48'd67108864;
	localparam logic [15:0] DEF_L0_THR      = 16'd4;
	localparam logic [39:0] DEF_FL_SLICE    = 40'd120000000;
	localparam logic [39:0] DEF_L0_SLICE    = 40'd250000000;
	localparam logic [39:0] DEF_CP_SLICE    = 40'd20000000;
	localparam logic [22:0] BONUS_PER_PCT   = 23'd5000000;
	localparam logic [8:0]  MAX_PCT         = 9'd300;
	localparam logic [8:0]  MIN_PCT         = 9'd100;

	// divider geometry: quotient bits, one restoring step a stage plus a saturation stage
	localparam int QW         = 9;
	localparam int DIV_STAGES = QW + 1;
	localparam int A_NW       = 23;
	localparam int A_DW       = 16;
	localparam int B_NW       = 55;
	localparam int B_DW       = 48;

	typedef struct packed {
		cat_t        cat;
		queue_t      queue;
		status_t     status;
		logic [39:0] slice;
		logic        ordered;
		logic        is_flush;
		logic [63:0] tv;
		logic [63:0] gv;
	} ctl_t;

endpackage

// ----- rtl/core/bg_task_priority_classifier.sv -----
// ----------------------------------------------------------------------------
// bg_task_priority_classifier
// sorts enqueue events into flush, level-0, compaction or other and sets queue,
// slice and vtime key
// ----------------------------------------------------------------------------
// One request enters per cycle unless the output stalls, through thirteen
// register stages: one classification stage, a ten-stage restoring divider for
// the pressure ratio (a saturation check then one quotient bit a stage), one
// stage for the bonus multiply and one for the vtime key, which is also the
// output register. A stalled output freezes the whole pipeline, so in_ready
// follows out_ready while a result waits. Configuration registers keep the
// resolved value, a written zero loads the default.
module bg_task_priority_classifier #(
	parameter logic [39:0] SHARED_QUANTUM = bgtpc_pkg::SHARED_QUANTUM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  thread_kind,
	input  logic        starts_at_level_zero,
	input  logic        metrics_found,
	input  logic [63:0] metrics_time,
	input  logic [63:0] current_time,
	input  logic        write_stalled,
	input  logic [15:0] imm_memtables,
	input  logic [47:0] memtable_bytes,
	input  logic [15:0] level0_files,
	input  logic [63:0] task_vtime,
	input  logic [63:0] global_vtime,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  task_category,
	output logic [1:0]  target_queue,
	output logic [39:0] slice_grant,
	output logic        vtime_ordered,
	output logic [63:0] vtime_key,
	output logic [1:0]  lookup_status
);

	localparam int QW  = bgtpc_pkg::QW;
	localparam int NS  = bgtpc_pkg::DIV_STAGES;
	localparam int ANW = bgtpc_pkg::A_NW;
	localparam int ADW = bgtpc_pkg::A_DW;
	localparam int BNW = bgtpc_pkg::B_NW;
	localparam int BDW = bgtpc_pkg::B_DW;
	localparam int ACW = ADW + QW + 1;
	localparam int BCW = BDW + QW + 1;

	// resolved configuration
	logic        fifo_q;
	logic [63:0] age_q;
	logic [15:0] imm_thr_q;
	logic [47:0] bytes_thr_q;
	logic [15:0] l0_thr_q;
	logic [39:0] fl_slice_q;
	logic [39:0] l0_slice_q;
	logic [39:0] cp_slice_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_q      <= 1'b0;
			age_q       <= bgtpc_pkg::DEF_MAX_AGE;
			imm_thr_q   <= bgtpc_pkg::DEF_IMM_THR;
			bytes_thr_q <= bgtpc_pkg::DEF_BYTES_THR;
			l0_thr_q    <= bgtpc_pkg::DEF_L0_THR;
			fl_slice_q  <= bgtpc_pkg::DEF_FL_SLICE;
			l0_slice_q  <= bgtpc_pkg::DEF_L0_SLICE;
			cp_slice_q  <= bgtpc_pkg::DEF_CP_SLICE;
		end else if (wr_en) begin
			unique case (wr_index)
				bgtpc_pkg::REG_FIFO: fifo_q <= wr_data[0];
				bgtpc_pkg::REG_MAX_AGE:
					age_q <= (wr_data == 64'd0) ? bgtpc_pkg::DEF_MAX_AGE : wr_data;
				bgtpc_pkg::REG_IMM_THR:
					imm_thr_q <= (wr_data[15:0] == 16'd0) ? bgtpc_pkg::DEF_IMM_THR
						: wr_data[15:0];
				bgtpc_pkg::REG_BYTES_THR:
					bytes_thr_q <= (wr_data[47:0] == 48'd0) ? bgtpc_pkg::DEF_BYTES_THR
						: wr_data[47:0];
				bgtpc_pkg::REG_L0_THR:
					l0_thr_q <= (wr_data[15:0] == 16'd0) ? bgtpc_pkg::DEF_L0_THR
						: wr_data[15:0];
				bgtpc_pkg::REG_FL_SLICE:
					fl_slice_q <= (wr_data[39:0] == 40'd0) ? bgtpc_pkg::DEF_FL_SLICE
						: wr_data[39:0];
				bgtpc_pkg::REG_L0_SLICE:
					l0_slice_q <= (wr_data[39:0] == 40'd0) ? bgtpc_pkg::DEF_L0_SLICE
						: wr_data[39:0];
				bgtpc_pkg::REG_CP_SLICE:
					cp_slice_q <= (wr_data[39:0] == 40'd0) ? bgtpc_pkg::DEF_CP_SLICE
						: wr_data[39:0];
				default: ;
			endcase
		end
	end

	// global advance: the pipeline moves unless the output holds a waiting result
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: classify and form the dividends ----------------
	bgtpc_pkg::ctl_t ctl_c;
	logic            stale_c;
	logic [ANW-1:0]  na_c;
	logic [ADW-1:0]  da_c;
	logic [BNW-1:0]  nb_c;

	always_comb begin
		stale_c = (current_time >= metrics_time) && ((current_time - metrics_time) > age_q);
		ctl_c          = '0;
		ctl_c.cat      = bgtpc_pkg::CAT_OTHER;
		ctl_c.queue    = bgtpc_pkg::Q_SHARED;
		ctl_c.status   = bgtpc_pkg::ST_OK;
		ctl_c.tv       = task_vtime;
		ctl_c.gv       = global_vtime;
		ctl_c.is_flush = (thread_kind == bgtpc_pkg::KIND_FLUSH);
		unique case (thread_kind)
			bgtpc_pkg::KIND_FLUSH: begin
				if (!metrics_found) ctl_c.status = bgtpc_pkg::ST_MISS;
				else if (stale_c) ctl_c.status = bgtpc_pkg::ST_STALE;
				else if (write_stalled || (imm_memtables >= imm_thr_q)
					|| (memtable_bytes >= bytes_thr_q))
					ctl_c.cat = bgtpc_pkg::CAT_FLUSH;
			end
			bgtpc_pkg::KIND_COMP: begin
				ctl_c.cat = bgtpc_pkg::CAT_COMP;
				if (starts_at_level_zero) begin
					if (!metrics_found) ctl_c.status = bgtpc_pkg::ST_MISS;
					else if (stale_c) ctl_c.status = bgtpc_pkg::ST_STALE;
					else if (level0_files >= l0_thr_q) ctl_c.cat = bgtpc_pkg::CAT_L0;
				end
			end
			default: ctl_c.status = bgtpc_pkg::ST_THREAD;
		endcase
		unique case (ctl_c.cat)
			bgtpc_pkg::CAT_FLUSH: begin
				ctl_c.queue = bgtpc_pkg::Q_PRIO;
				ctl_c.slice = fl_slice_q;
			end
			bgtpc_pkg::CAT_L0: begin
				ctl_c.queue = bgtpc_pkg::Q_PRIO;
				ctl_c.slice = l0_slice_q;
			end
			bgtpc_pkg::CAT_COMP: begin
				ctl_c.queue = bgtpc_pkg::Q_COMP;
				ctl_c.slice = cp_slice_q;
			end
			default: ctl_c.slice = SHARED_QUANTUM;
		endcase
		ctl_c.ordered = (ctl_c.queue == bgtpc_pkg::Q_PRIO) && !fifo_q;
		// unit a serves the memtable count for flush, the level-0 count otherwise
		na_c = ctl_c.is_flush ? ANW'(ANW'(imm_memtables) * ANW'(100))
			: ANW'(ANW'(level0_files) * ANW'(100));
		da_c = ctl_c.is_flush ? imm_thr_q : l0_thr_q;
		nb_c = BNW'(BNW'(memtable_bytes) * BNW'(100));
	end

	logic            vld_s1;
	bgtpc_pkg::ctl_t ctl_s1;
	logic [ANW-1:0]  na_s1;
	logic [ADW-1:0]  da_s1;
	logic [BNW-1:0]  nb_s1;
	logic [BDW-1:0]  db_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_c;
			na_s1  <= na_c;
			da_s1  <= da_c;
			nb_s1  <= nb_c;
			db_s1  <= bytes_thr_q;
		end
	end

	// ---------------- divider stages ----------------
	logic            vld_s  [NS];
	bgtpc_pkg::ctl_t ctl_s  [NS];
	logic [ANW-1:0]  rema_s [NS];
	logic [ADW-1:0]  da_s   [NS];
	logic [QW-1:0]   qa_s   [NS];
	logic            sata_s [NS];
	logic [BNW-1:0]  remb_s [NS];
	logic [BDW-1:0]  db_s   [NS];
	logic [QW-1:0]   qb_s   [NS];
	logic            satb_s [NS];

	// saturation stage: quotient of 512 or more clamps anyway
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (adv) vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[0]  <= ctl_s1;
			rema_s[0] <= na_s1;
			da_s[0]   <= da_s1;
			qa_s[0]   <= '0;
			sata_s[0] <= ACW'(na_s1) >= (ACW'(da_s1) << QW);
			remb_s[0] <= nb_s1;
			db_s[0]   <= db_s1;
			qb_s[0]   <= '0;
			satb_s[0] <= BCW'(nb_s1) >= (BCW'(db_s1) << QW);
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_div
		localparam int B = QW - k;
		logic [ACW-1:0] sha;
		logic [BCW-1:0] shb;
		logic           ta;
		logic           tb;

		assign sha = ACW'(da_s[k-1]) << B;
		assign shb = BCW'(db_s[k-1]) << B;
		assign ta  = ACW'(rema_s[k-1]) >= sha;
		assign tb  = BCW'(remb_s[k-1]) >= shb;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (adv) vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_s[k]  <= ctl_s[k-1];
				da_s[k]   <= da_s[k-1];
				db_s[k]   <= db_s[k-1];
				sata_s[k] <= sata_s[k-1];
				satb_s[k] <= satb_s[k-1];
				rema_s[k] <= ta ? (rema_s[k-1] - ANW'(sha)) : rema_s[k-1];
				remb_s[k] <= tb ? (remb_s[k-1] - BNW'(shb)) : remb_s[k-1];
				qa_s[k]   <= qa_s[k-1] | (QW'(ta) << B);
				qb_s[k]   <= qb_s[k-1] | (QW'(tb) << B);
			end
		end
	end

	// ---------------- ratio clamp and bonus multiply ----------------
	logic [QW-1:0] ca_c;
	logic [QW-1:0] cb_c;
	logic [QW-1:0] ratio_c;

	always_comb begin
		ca_c = (sata_s[NS-1] || (qa_s[NS-1] > bgtpc_pkg::MAX_PCT)) ? bgtpc_pkg::MAX_PCT
			: qa_s[NS-1];
		cb_c = (satb_s[NS-1] || (qb_s[NS-1] > bgtpc_pkg::MAX_PCT)) ? bgtpc_pkg::MAX_PCT
			: qb_s[NS-1];
		ratio_c = (ctl_s[NS-1].is_flush && (cb_c > ca_c)) ? cb_c : ca_c;
		if (ratio_c < bgtpc_pkg::MIN_PCT) ratio_c = bgtpc_pkg::MIN_PCT;
	end

	logic            vld_s2;
	bgtpc_pkg::ctl_t ctl_s2;
	logic [31:0]     bonus_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s[NS-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2   <= ctl_s[NS-1];
			bonus_s2 <= 32'(32'(ratio_c) * 32'(bgtpc_pkg::BONUS_PER_PCT));
		end
	end

	// ---------------- vtime key and output register ----------------
	logic [63:0] floor_c;
	logic [63:0] diff_c;
	logic [63:0] key_c;

	always_comb begin
		floor_c = (ctl_s2.gv > 64'(bonus_s2)) ? (ctl_s2.gv - 64'(bonus_s2)) : 64'd0;
		diff_c  = ctl_s2.tv - floor_c;
		key_c   = diff_c[63] ? ctl_s2.tv : floor_c;
		if (!ctl_s2.ordered) key_c = 64'd0;
	end

	logic            vld_s3;
	bgtpc_pkg::ctl_t ctl_s3;
	logic [63:0]     key_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3 <= ctl_s2;
			key_s3 <= key_c;
		end
	end

	assign out_valid     = vld_s3;
	assign task_category = ctl_s3.cat;
	assign target_queue  = ctl_s3.queue;
	assign slice_grant   = ctl_s3.slice;
	assign vtime_ordered = ctl_s3.ordered;
	assign vtime_key     = key_s3;
	assign lookup_status = ctl_s3.status;

endmodule

// ----- rtl/core/bgtpc_checker.sv -----
// ----------------------------------------------------------------------------
// bgtpc_checker
// port-level checks of the background task priority classifier
// ----------------------------------------------------------------------------
module bgtpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  task_category,
	input logic [1:0]  target_queue,
	input logic        vtime_ordered,
	input logic [63:0] vtime_key,
	input logic [1:0]  lookup_status
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(task_category)
			&& $stable(vtime_key))
		else $error("stalled result changed");

	// a waiting result blocks new requests
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while output stalled");

	// vtime ordering only in the priority queue
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vtime_ordered |-> target_queue == bgtpc_pkg::Q_PRIO)
		else $error("vtime order outside priority queue");

	// no key without ordering
	a_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !vtime_ordered |-> vtime_key == 64'd0)
		else $error("key set while not vtime ordered");

	// flush results need good metrics
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && task_category == bgtpc_pkg::CAT_FLUSH
			|-> target_queue == bgtpc_pkg::Q_PRIO && lookup_status == bgtpc_pkg::ST_OK)
		else $error("flush result inconsistent");

endmodule

bind bg_task_priority_classifier bgtpc_checker u_bgtpc_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the background task priority classifier against its own predictor:
// directed edge cases, several register settings, random enqueue events under
// random and long output stalls
// ----------------------------------------------------------------------------
module testbench;

	// one enqueue event as driven on the input channel
	typedef struct {
		logic [1:0]  kind;
		logic        lvl0;
		logic        found;
		logic [63:0] mtime;
		logic [63:0] now;
		logic        stall;
		logic [15:0] imm;
		logic [47:0] bytes;
		logic [15:0] l0f;
		logic [63:0] tv;
		logic [63:0] gv;
	} event_t;

	// one classification as seen on the output channel
	typedef struct {
		bgtpc_pkg::cat_t    cat;
		bgtpc_pkg::queue_t  queue;
		logic [39:0]        slice;
		logic               ordered;
		logic [63:0]        key;
		bgtpc_pkg::status_t status;
	} class_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [63:0] wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  thread_kind;
	logic        starts_at_level_zero;
	logic        metrics_found;
	logic [63:0] metrics_time;
	logic [63:0] current_time;
	logic        write_stalled;
	logic [15:0] imm_memtables;
	logic [47:0] memtable_bytes;
	logic [15:0] level0_files;
	logic [63:0] task_vtime;
	logic [63:0] global_vtime;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  task_category;
	logic [1:0]  target_queue;
	logic [39:0] slice_grant;
	logic        vtime_ordered;
	logic [63:0] vtime_key;
	logic [1:0]  lookup_status;

	// shadow copy of the register file, raw values as written
	logic        cfg_fifo;
	logic [63:0] cfg_max_age;
	logic [15:0] cfg_imm_thr;
	logic [47:0] cfg_bytes_thr;
	logic [15:0] cfg_l0_thr;
	logic [39:0] cfg_fl_slice;
	logic [39:0] cfg_l0_slice;
	logic [39:0] cfg_cp_slice;

	class_t pending_class[$];
	int     n_fail;
	int     n_checked;
	int     n_sent;
	int     idle_in;
	int     idle_out;
	int     hold_cycles;

	bg_task_priority_classifier u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.wr_en                (wr_en),
		.wr_index             (wr_index),
		.wr_data              (wr_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.thread_kind          (thread_kind),
		.starts_at_level_zero (starts_at_level_zero),
		.metrics_found        (metrics_found),
		.metrics_time         (metrics_time),
		.current_time         (current_time),
		.write_stalled        (write_stalled),
		.imm_memtables        (imm_memtables),
		.memtable_bytes       (memtable_bytes),
		.level0_files         (level0_files),
		.task_vtime           (task_vtime),
		.global_vtime         (global_vtime),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.task_category        (task_category),
		.target_queue         (target_queue),
		.slice_grant          (slice_grant),
		.vtime_ordered        (vtime_ordered),
		.vtime_key            (vtime_key),
		.lookup_status        (lookup_status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// effective thresholds, a zero register means the default
	function automatic logic [63:0] stale_after();
		return (cfg_max_age != 0) ? cfg_max_age : bgtpc_pkg::DEF_MAX_AGE;
	endfunction

	function automatic logic [63:0] imm_limit();
		return (cfg_imm_thr != 0) ? 64'(cfg_imm_thr) : 64'(bgtpc_pkg::DEF_IMM_THR);
	endfunction

	function automatic logic [63:0] bytes_limit();
		return (cfg_bytes_thr != 0) ? 64'(cfg_bytes_thr) : 64'(bgtpc_pkg::DEF_BYTES_THR);
	endfunction

	function automatic logic [63:0] l0_limit();
		return (cfg_l0_thr != 0) ? 64'(cfg_l0_thr) : 64'(bgtpc_pkg::DEF_L0_THR);
	endfunction

	// percent of threshold, capped at the top of the pressure range
	function automatic logic [63:0] pressure_pct(logic [63:0] v, logic [63:0] thr);
		logic [63:0] r;
		r = v * 100 / thr;
		return (r > 64'(bgtpc_pkg::MAX_PCT)) ? 64'(bgtpc_pkg::MAX_PCT) : r;
	endfunction

	// expected classification of one event under the current registers
	function automatic class_t classify(event_t e);
		class_t      c;
		logic        stale;
		logic [63:0] ratio;
		logic [63:0] ri;
		logic [63:0] rm;
		logic [63:0] bonus;
		logic [63:0] floor_v;
		logic [63:0] diff;
		stale = (e.now >= e.mtime) && ((e.now - e.mtime) > stale_after());
		c.cat = bgtpc_pkg::CAT_OTHER;
		c.queue = bgtpc_pkg::Q_SHARED;
		c.slice = bgtpc_pkg::SHARED_QUANTUM_DEF;
		c.ordered = 1'b0;
		c.key = '0;
		c.status = bgtpc_pkg::ST_OK;
		ratio = 64'(bgtpc_pkg::MIN_PCT);
		if (e.kind == bgtpc_pkg::KIND_FLUSH) begin
			if (!e.found)
				c.status = bgtpc_pkg::ST_MISS;
			else if (stale)
				c.status = bgtpc_pkg::ST_STALE;
			else if (e.stall || e.imm >= imm_limit() || e.bytes >= bytes_limit()) begin
				ri = pressure_pct(64'(e.imm), imm_limit());
				rm = pressure_pct(64'(e.bytes), bytes_limit());
				c.cat = bgtpc_pkg::CAT_FLUSH;
				ratio = (ri > rm) ? ri : rm;
			end
		end else if (e.kind == bgtpc_pkg::KIND_COMP) begin
			c.cat = bgtpc_pkg::CAT_COMP;
			if (e.lvl0) begin
				if (!e.found)
					c.status = bgtpc_pkg::ST_MISS;
				else if (stale)
					c.status = bgtpc_pkg::ST_STALE;
				else if (e.l0f >= l0_limit()) begin
					c.cat = bgtpc_pkg::CAT_L0;
					ratio = pressure_pct(64'(e.l0f), l0_limit());
				end
			end
		end else begin
			c.status = bgtpc_pkg::ST_THREAD;
		end
		if (ratio < 64'(bgtpc_pkg::MIN_PCT))
			ratio = 64'(bgtpc_pkg::MIN_PCT);
		if (c.cat == bgtpc_pkg::CAT_FLUSH || c.cat == bgtpc_pkg::CAT_L0) begin
			c.queue = bgtpc_pkg::Q_PRIO;
			if (c.cat == bgtpc_pkg::CAT_FLUSH)
				c.slice = (cfg_fl_slice != 0) ? cfg_fl_slice : bgtpc_pkg::DEF_FL_SLICE;
			else
				c.slice = (cfg_l0_slice != 0) ? cfg_l0_slice : bgtpc_pkg::DEF_L0_SLICE;
			if (!cfg_fifo) begin
				// bonus pulls the key forward, but never past an earlier task vtime
				bonus = 64'(bgtpc_pkg::BONUS_PER_PCT) * ratio;
				floor_v = (e.gv > bonus) ? e.gv - bonus : 64'd0;
				diff = e.tv - floor_v;
				c.ordered = 1'b1;
				c.key = diff[63] ? e.tv : floor_v;
			end
		end else if (c.cat == bgtpc_pkg::CAT_COMP) begin
			c.queue = bgtpc_pkg::Q_COMP;
			c.slice = (cfg_cp_slice != 0) ? cfg_cp_slice : bgtpc_pkg::DEF_CP_SLICE;
		end
		return c;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// count near a threshold most of the time, any value otherwise
	function automatic logic [63:0] near(logic [63:0] thr);
		logic [63:0] span;
		span = (thr > 64'd1000000) ? 64'd1000000 : thr;
		case ($urandom_range(5))
			0: return thr;
			1: return thr - 1;
			2: return thr * 3 + $urandom_range(3) - 1;
			3: return rand64();
			default: return thr + $urandom_range(0, 32'(span) * 2) - span;
		endcase
	endfunction

	// random event: mostly well formed with fresh metrics near the thresholds
	function automatic event_t random_event();
		event_t      e;
		logic [63:0] delta;
		logic [63:0] v;
		int          r;
		r = $urandom_range(19);
		if (r < 8)
			e.kind = bgtpc_pkg::KIND_FLUSH;
		else if (r < 16)
			e.kind = bgtpc_pkg::KIND_COMP;
		else
			e.kind = 2'($urandom_range(3));
		e.lvl0 = ($urandom_range(3) != 0);
		e.found = ($urandom_range(9) != 0);
		e.now = rand64();
		case ($urandom_range(7))
			0: delta = stale_after();
			1: delta = stale_after() + 1;
			2: delta = -64'($urandom_range(1, 1000));
			3: delta = rand64();
			default: delta = 64'($urandom) % stale_after();
		endcase
		e.mtime = ($urandom_range(15) == 0) ? rand64() : e.now - delta;
		e.stall = ($urandom_range(4) == 0);
		v = near(imm_limit());
		e.imm = (v > 64'hFFFF) ? 16'($urandom) : v[15:0];
		v = near(bytes_limit());
		e.bytes = (v > 64'hFFFF_FFFF_FFFF) ? 48'(rand64()) : v[47:0];
		v = near(l0_limit());
		e.l0f = (v > 64'hFFFF) ? 16'($urandom) : v[15:0];
		e.gv = ($urandom_range(3) == 0) ? 64'($urandom_range(0, 1600000000)) : rand64();
		case ($urandom_range(3))
			0: e.tv = rand64();
			1: e.tv = e.gv;
			default: e.tv = e.gv - 64'($urandom_range(0, 1600000000));
		endcase
		return e;
	endfunction

	// one request on the input channel, returns after the accepting edge or after a random gap
	task automatic send_event(event_t e);
		logic took;
		thread_kind <= e.kind;
		starts_at_level_zero <= e.lvl0;
		metrics_found <= e.found;
		metrics_time <= e.mtime;
		current_time <= e.now;
		write_stalled <= e.stall;
		imm_memtables <= e.imm;
		memtable_bytes <= e.bytes;
		level0_files <= e.l0f;
		task_vtime <= e.tv;
		global_vtime <= e.gv;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = in_ready;
			if (took)
				pending_class.push_back(classify(e));
			@(posedge clk);
		end while (!took);
		n_sent++;
		// random gap after the request
		if ($urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// stop sending and let the pipeline empty out
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_class.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// one write, the caller drops the write enable after the last one
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			bgtpc_pkg::REG_FIFO:      cfg_fifo = val[0];
			bgtpc_pkg::REG_MAX_AGE:   cfg_max_age = val;
			bgtpc_pkg::REG_IMM_THR:   cfg_imm_thr = val[15:0];
			bgtpc_pkg::REG_BYTES_THR: cfg_bytes_thr = val[47:0];
			bgtpc_pkg::REG_L0_THR:    cfg_l0_thr = val[15:0];
			bgtpc_pkg::REG_FL_SLICE:  cfg_fl_slice = val[39:0];
			bgtpc_pkg::REG_L0_SLICE:  cfg_l0_slice = val[39:0];
			default:                  cfg_cp_slice = val[39:0];
		endcase
	endtask

	// all eight registers in one go
	task automatic load_regs(logic fifo, logic [63:0] age, logic [15:0] imm_thr,
			logic [47:0] byte_lim, logic [15:0] l0_thr, logic [39:0] fl,
			logic [39:0] l0s, logic [39:0] cp);
		write_reg(bgtpc_pkg::REG_FIFO, {63'd0, fifo});
		write_reg(bgtpc_pkg::REG_MAX_AGE, age);
		write_reg(bgtpc_pkg::REG_IMM_THR, {48'd0, imm_thr});
		write_reg(bgtpc_pkg::REG_BYTES_THR, {16'd0, byte_lim});
		write_reg(bgtpc_pkg::REG_L0_THR, {48'd0, l0_thr});
		write_reg(bgtpc_pkg::REG_FL_SLICE, {24'd0, fl});
		write_reg(bgtpc_pkg::REG_L0_SLICE, {24'd0, l0s});
		write_reg(bgtpc_pkg::REG_CP_SLICE, {24'd0, cp});
		wr_en <= 1'b0;
	endtask

	function automatic event_t make_event(logic [1:0] kind, logic lvl0, logic found,
			logic [63:0] mtime, logic [63:0] now, logic stall, logic [15:0] imm,
			logic [47:0] bytes, logic [15:0] l0f, logic [63:0] tv, logic [63:0] gv);
		event_t e;
		e.kind = kind; e.lvl0 = lvl0; e.found = found; e.mtime = mtime;
		e.now = now; e.stall = stall; e.imm = imm; e.bytes = bytes;
		e.l0f = l0f; e.tv = tv; e.gv = gv;
		return e;
	endfunction

	// directed corner cases under the default registers
	task automatic test_directed();
		logic [63:0] t0;
		logic [1:0]  kf;
		logic [1:0]  kc;
		t0 = 64'd10_000_000_000;
		kf = bgtpc_pkg::KIND_FLUSH;
		kc = bgtpc_pkg::KIND_COMP;
		// unknown thread kinds, including the unused code
		send_event(make_event(2'd0, 1, 1, t0, t0, 1, '1, '1, '1, '1, '1));
		send_event(make_event(2'd3, 0, 0, '0, '0, 0, '0, '0, '0, '0, '0));
		// flush: missing, stale, exactly at the age limit, future timestamp
		send_event(make_event(kf, 0, 0, t0, t0, 1, 16'd5, '0, '0, t0, t0));
		send_event(make_event(kf, 0, 1, t0 - bgtpc_pkg::DEF_MAX_AGE - 1, t0, 1, 16'd5,
			'0, '0, t0, t0));
		send_event(make_event(kf, 0, 1, t0 - bgtpc_pkg::DEF_MAX_AGE, t0, 1, 16'd5,
			'0, '0, t0, t0));
		send_event(make_event(kf, 0, 1, '1, '0, 0, 16'd1, '0, '0, t0, t0));
		// flush with no pressure, then each trigger alone
		send_event(make_event(kf, 0, 1, t0, t0, 0, '0, '0, '0, t0, t0));
		send_event(make_event(kf, 0, 1, t0, t0, 1, '0, '0, '0, t0, t0));
		send_event(make_event(kf, 0, 1, t0, t0, 0, 16'd2, '0, '0, t0, t0));
		send_event(make_event(kf, 0, 1, t0, t0, 0, '0, 48'd67108864, '0, t0, t0));
		send_event(make_event(kf, 0, 1, t0, t0, 0, '1, '1, '1, '1, '0));
		// bonus larger than global vtime, and an earlier task vtime
		send_event(make_event(kf, 1, 1, t0, t0, 0, '1, '0, '0, 64'd5, 64'd100));
		send_event(make_event(kf, 1, 1, t0, t0, 0, 16'd1, '0, '0, 64'd7, t0));
		send_event(make_event(kf, 1, 1, t0, t0, 0, 16'd1, '0, '0,
			64'h8000_0000_0000_0000, '0));
		// compaction: not level zero ignores metrics, then level-0 paths
		send_event(make_event(kc, 0, 0, '1, '0, 0, '0, '0, '1, '0, '0));
		send_event(make_event(kc, 1, 0, t0, t0, 0, '0, '0, 16'd10, t0, t0));
		send_event(make_event(kc, 1, 1, '0, '1, 0, '0, '0, 16'd10, t0, t0));
		send_event(make_event(kc, 1, 1, t0, t0, 0, '0, '0, 16'd3, t0, t0));
		send_event(make_event(kc, 1, 1, t0, t0, 0, '0, '0, 16'd4, t0, t0));
		send_event(make_event(kc, 1, 1, t0, t0, 0, '0, '0, 16'd9, '0, '1));
		send_event(make_event(kc, 1, 1, t0, t0, 0, '0, '0, '1, '1, '1));
		drain();
	endtask

	// a batch of random events under one register setting
	task automatic random_batch(int count);
		repeat (count)
			send_event(random_event());
		drain();
	endtask

	// register extremes, each followed by random traffic
	task automatic test_register_settings();
		load_regs(1'b1, 64'd1, 16'd1, 48'd1, 16'd1, 40'd1, 40'd1, 40'd1);
		random_batch(60);
		load_regs(1'b0, '1, '1, '1, '1, '1, '1, '1);
		random_batch(60);
		load_regs(1'b0, 64'($urandom), 16'($urandom_range(1, 50)),
			48'($urandom_range(1, 100000)), 16'($urandom_range(1, 50)),
			40'($urandom), 40'($urandom), 40'($urandom));
		random_batch(60);
		load_regs(1'b0, '0, '0, '0, '0, '0, '0, '0);
	endtask

	// receiver holds off long enough to fill and stall the pipeline
	task automatic test_backpressure();
		hold_cycles = 200;
		repeat (60)
			send_event(random_event());
		drain();
	endtask

	// the three idling mixes over random traffic
	task automatic test_random_traffic();
		idle_in = 21; idle_out = 63;
		random_batch(350);
		load_regs(1'b1, 64'd1000, 16'd3, 48'd4096, 16'd8, 40'd777, 40'd888, 40'd999);
		idle_in = 63; idle_out = 21;
		random_batch(350);
		load_regs(1'b0, '0, 16'd2, '0, 16'd6, '0, '0, '0);
		idle_in = 0; idle_out = 0;
		random_batch(350);
	endtask

	// receiver side: random ready, long hold when asked
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_out);
		end
	end

	// result check, sampled mid-cycle where every signal is settled
	initial begin
		class_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && out_ready) begin
				n_checked++;
				if (pending_class.size() == 0) begin
					$error("result with no pending request");
					n_fail++;
				end else begin
					want = pending_class.pop_front();
					if (task_category !== want.cat) begin
						$error("task_category expected %0d got %0d", want.cat, task_category);
						n_fail++;
					end
					if (target_queue !== want.queue) begin
						$error("target_queue expected %0d got %0d", want.queue, target_queue);
						n_fail++;
					end
					if (slice_grant !== want.slice) begin
						$error("slice_grant expected %0d got %0d", want.slice, slice_grant);
						n_fail++;
					end
					if (vtime_ordered !== want.ordered) begin
						$error("vtime_ordered expected %0d got %0d", want.ordered, vtime_ordered);
						n_fail++;
					end
					if (vtime_key !== want.key) begin
						$error("vtime_key expected %0d got %0d", want.key, vtime_key);
						n_fail++;
					end
					if (lookup_status !== want.status) begin
						$error("lookup_status expected %0d got %0d", want.status, lookup_status);
						n_fail++;
					end
				end
			end
		end
	end

	// overall limit on the run
	initial begin
		#30_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0; wr_index = '0; wr_data = '0;
		in_valid = 1'b0;
		thread_kind = '0; starts_at_level_zero = 1'b0; metrics_found = 1'b0;
		metrics_time = '0; current_time = '0; write_stalled = 1'b0;
		imm_memtables = '0; memtable_bytes = '0; level0_files = '0;
		task_vtime = '0; global_vtime = '0;
		out_ready = 1'b0;
		cfg_fifo = 1'b0; cfg_max_age = '0; cfg_imm_thr = '0; cfg_bytes_thr = '0;
		cfg_l0_thr = '0; cfg_fl_slice = '0; cfg_l0_slice = '0; cfg_cp_slice = '0;
		n_fail = 0; n_checked = 0; n_sent = 0;
		idle_in = 21; idle_out = 63; hold_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_regs(1'b0, '0, '0, '0, '0, '0, '0, '0);
		test_directed();
		test_register_settings();
		test_backpressure();
		test_random_traffic();
		drain();
		if (pending_class.size() != 0) begin
			$error("%0d requests never produced a result", pending_class.size());
			n_fail++;
		end
		$display("sent %0d enqueue events, checked %0d classifications", n_sent, n_checked);
		$display("covered defaults, register extremes, fifo mode and long output stalls");
		if (n_fail == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/bgtpc_pkg.sv
rtl/core/bg_task_priority_classifier.sv
rtl/core/bgtpc_checker.sv
test/testbench.sv
